// ===== src/rc4_pkg.sv =====
// ----------------------------------------------------------------------------
// RC4 package
// Shared constants, command codes and memory request types of the RC4 core.
// ----------------------------------------------------------------------------
package rc4_pkg;

  // Byte and table geometry.
  localparam int unsigned ByteW     = 8;
  localparam int unsigned PermDepth = 256;
  localparam int unsigned PermAw    = $clog2(PermDepth);
  localparam int unsigned KeyDepth  = 256;
  localparam int unsigned KeyAw     = $clog2(KeyDepth);
  localparam int unsigned KeyCntW   = KeyAw + 1;

  // Longest key that is kept; later key bytes are dropped.
  localparam logic [KeyCntW-1:0] MaxKeyBytes = KeyCntW'(256);

  // Item kinds carried on tuser.
  localparam logic CmdKey  = 1'b0;
  localparam logic CmdData = 1'b1;

  // Access request to the permutation memory.
  typedef struct packed {
    logic              clr;      // mark every entry as holding its index
    logic              rd_en;
    logic [PermAw-1:0] rd_addr;
    logic              wr_en;
    logic [PermAw-1:0] wr_addr;
    logic [ByteW-1:0]  wr_data;
  } perm_req_t;

  // Access request to the key memory.
  typedef struct packed {
    logic             rd_en;
    logic [KeyAw-1:0] rd_addr;
    logic             wr_en;
    logic [KeyAw-1:0] wr_addr;
    logic [ByteW-1:0] wr_data;
  } key_req_t;

endpackage

// ===== src/rc4_perm_ram.sv =====
// ----------------------------------------------------------------------------
// RC4 permutation memory
// Single-port-read, single-port-write synchronous memory of the permutation.
// A valid bit per entry lets the whole table return to the identity with a
// single clear: an entry never written since the last clear reads as its own index.
// ----------------------------------------------------------------------------
module rc4_perm_ram (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rc4_pkg::perm_req_t        req_i,
  output logic [rc4_pkg::ByteW-1:0] rd_data_o
);

  logic [rc4_pkg::ByteW-1:0]  mem [rc4_pkg::PermDepth];
  logic [rc4_pkg::PermDepth-1:0] valid_q;
  logic [rc4_pkg::ByteW-1:0]  rd_mem_q;
  logic                       rd_vld_q;
  logic [rc4_pkg::PermAw-1:0] rd_addr_q;

  // Memory array write and registered read.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_mem_q  <= mem[req_i.rd_addr];
      rd_vld_q  <= valid_q[req_i.rd_addr];
      rd_addr_q <= req_i.rd_addr;
    end
  end

  // Per-entry valid bits, cleared at reset and at the start of a key schedule.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.clr) begin
      valid_q <= '0;
    end else if (req_i.wr_en) begin
      valid_q[req_i.wr_addr] <= 1'b1;
    end
  end

  // An entry not written since the last clear holds its own index.
  assign rd_data_o = rd_vld_q ? rd_mem_q : rd_addr_q;

endmodule

// ===== src/rc4_key_ram.sv =====
// ----------------------------------------------------------------------------
// RC4 key memory
// Synchronous memory that keeps the key bytes in arrival order.
// ----------------------------------------------------------------------------
module rc4_key_ram (
  input  logic                      clk_i,
  input  rc4_pkg::key_req_t         req_i,
  output logic [rc4_pkg::ByteW-1:0] rd_data_o
);

  logic [rc4_pkg::ByteW-1:0] mem [rc4_pkg::KeyDepth];
  logic [rc4_pkg::ByteW-1:0] rd_data_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/rc4_stream_cipher_core.sv =====
// ----------------------------------------------------------------------------
// RC4 stream cipher core
// Loads a key, runs the RC4 key schedule and XORs data bytes with keystream.
// ----------------------------------------------------------------------------
// Each input transaction carries one byte on tdata and its kind on tuser: a
// key byte (tuser low) or a data byte (tuser high). A key byte is stored when
// it is accepted; the key byte marked with tlast also starts the key schedule
// over the identity permutation, one swap step per table entry (read S[i] and
// the key byte, update j and read S[j], write S[i], write S[j]), and no
// transaction is accepted until it ends. A data byte passes ST_DA, ST_DB and
// ST_DC, where its result is loaded into the output register once that is free;
// the next byte is accepted only after that. The steps follow the chain of
// dependent reads of the permutation memory, which has one registered read
// port. Encryption and decryption are the same operation. Key bytes beyond
// 256 are dropped. Before any key, the identity permutation is used.
module rc4_stream_cipher_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Input stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [rc4_pkg::ByteW-1:0] s_axis_tdata,   // [7:0] byte_value
  input  logic                      s_axis_tuser,   // [0] cmd
  input  logic                      s_axis_tlast,   // last_key
  // Output stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [rc4_pkg::ByteW-1:0] m_axis_tdata    // [7:0] data_out
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DA   = 3'd1;  // S[i] arrives, read S[j]
  localparam logic [2:0] ST_DB   = 3'd2;  // S[j] arrives, write S[i], read S[t]
  localparam logic [2:0] ST_DC   = 3'd3;  // write S[j], load result
  localparam logic [2:0] ST_KR   = 3'd4;  // read S[k] and key byte
  localparam logic [2:0] ST_KA   = 3'd5;  // update j, read S[j]
  localparam logic [2:0] ST_KB   = 3'd6;  // write S[k]
  localparam logic [2:0] ST_KC   = 3'd7;  // write S[j], next step

  logic [2:0]                    state_q, state_d;
  logic [rc4_pkg::PermAw-1:0]    idx_i_q, idx_i_d;
  logic [rc4_pkg::PermAw-1:0]    idx_j_q, idx_j_d;
  logic [rc4_pkg::KeyCntW-1:0]   key_cnt_q, key_cnt_d;
  logic [rc4_pkg::KeyAw-1:0]     kidx_q, kidx_d;
  logic                          out_valid_q, out_valid_d;
  logic [rc4_pkg::ByteW-1:0]     out_data_q, out_data_d;
  logic [rc4_pkg::ByteW-1:0]     si_q, si_d;
  logic [rc4_pkg::ByteW-1:0]     sj_q, sj_d;
  logic [rc4_pkg::PermAw-1:0]    t_q, t_d;
  logic [rc4_pkg::ByteW-1:0]     byte_q, byte_d;

  rc4_pkg::perm_req_t            perm_req;
  rc4_pkg::key_req_t             key_req;
  logic [rc4_pkg::ByteW-1:0]     perm_rd;
  logic [rc4_pkg::ByteW-1:0]     key_rd;
  logic                          in_acc;
  logic [rc4_pkg::ByteW-1:0]     ks_byte;
  logic [rc4_pkg::KeyCntW-1:0]   kidx_inc;

  // Memories.
  rc4_perm_ram u_perm_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (perm_req),
    .rd_data_o (perm_rd)
  );

  rc4_key_ram u_key_ram (
    .clk_i     (clk_i),
    .req_i     (key_req),
    .rd_data_o (key_rd)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Keystream byte, forwarded around the swap writes that are still in flight.
  always_comb begin
    if (t_q == idx_j_q) begin
      ks_byte = si_q;
    end else if (t_q == idx_i_q) begin
      ks_byte = sj_q;
    end else begin
      ks_byte = perm_rd;
    end
  end

  // Cyclic key index for the schedule.
  assign kidx_inc = {1'b0, kidx_q} + rc4_pkg::KeyCntW'(1);

  // Sequencer and datapath.
  always_comb begin
    state_d     = state_q;
    idx_i_d     = idx_i_q;
    idx_j_d     = idx_j_q;
    key_cnt_d   = key_cnt_q;
    kidx_d      = kidx_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    si_d        = si_q;
    sj_d        = sj_q;
    t_d         = t_q;
    byte_d      = byte_q;
    perm_req    = '0;
    key_req     = '0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == rc4_pkg::CmdData) begin
            idx_i_d          = idx_i_q + rc4_pkg::PermAw'(1);
            perm_req.rd_en   = 1'b1;
            perm_req.rd_addr = idx_i_d;
            byte_d           = s_axis_tdata;
            state_d          = ST_DA;
          end else begin
            if (key_cnt_q < rc4_pkg::MaxKeyBytes) begin
              key_req.wr_en   = 1'b1;
              key_req.wr_addr = key_cnt_q[rc4_pkg::KeyAw-1:0];
              key_req.wr_data = s_axis_tdata;
              key_cnt_d       = key_cnt_q + rc4_pkg::KeyCntW'(1);
            end
            if (s_axis_tlast) begin
              perm_req.clr = 1'b1;
              idx_i_d      = '0;
              idx_j_d      = '0;
              kidx_d       = '0;
              state_d      = ST_KR;
            end
          end
        end
      end
      ST_DA: begin
        idx_j_d          = idx_j_q + perm_rd;
        si_d             = perm_rd;
        perm_req.rd_en   = 1'b1;
        perm_req.rd_addr = idx_j_d;
        state_d          = ST_DB;
      end
      ST_DB: begin
        sj_d             = perm_rd;
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = idx_i_q;
        perm_req.wr_data = perm_rd;
        t_d              = si_q + perm_rd;
        perm_req.rd_en   = 1'b1;
        perm_req.rd_addr = t_d;
        state_d          = ST_DC;
      end
      ST_DC: begin
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = idx_j_q;
        perm_req.wr_data = si_q;
        if (!out_valid_q || m_axis_tready) begin
          out_data_d  = byte_q ^ ks_byte;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_KR: begin
        perm_req.rd_en   = 1'b1;
        perm_req.rd_addr = idx_i_q;
        key_req.rd_en    = 1'b1;
        key_req.rd_addr  = kidx_q;
        state_d          = ST_KA;
      end
      ST_KA: begin
        idx_j_d          = idx_j_q + perm_rd + key_rd;
        si_d             = perm_rd;
        perm_req.rd_en   = 1'b1;
        perm_req.rd_addr = idx_j_d;
        state_d          = ST_KB;
      end
      ST_KB: begin
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = idx_i_q;
        perm_req.wr_data = perm_rd;
        state_d          = ST_KC;
      end
      ST_KC: begin
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = idx_j_q;
        perm_req.wr_data = si_q;
        idx_i_d          = idx_i_q + rc4_pkg::PermAw'(1);
        kidx_d           = (kidx_inc == key_cnt_q) ? '0 : kidx_inc[rc4_pkg::KeyAw-1:0];
        if (idx_i_q == {rc4_pkg::PermAw{1'b1}}) begin
          idx_j_d   = '0;
          key_cnt_d = '0;
          state_d   = ST_IDLE;
        end else begin
          state_d   = ST_KR;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_i_q     <= '0;
      idx_j_q     <= '0;
      key_cnt_q   <= '0;
      kidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_i_q     <= idx_i_d;
      idx_j_q     <= idx_j_d;
      key_cnt_q   <= key_cnt_d;
      kidx_q      <= kidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    si_q       <= si_d;
    sj_q       <= sj_d;
    t_q        <= t_d;
    byte_q     <= byte_d;
  end

`ifndef ASSERT_OFF
  // The key count never passes the longest key.
  a_key_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_cnt_q <= rc4_pkg::MaxKeyBytes)
    else $error("key count beyond the longest key");

  // A new result only appears after the final step of a data byte.
  a_out_from_dc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DC)
    else $error("result loaded outside the final data step");

  // The last schedule step leaves both indices and the key count at zero.
  a_sched_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_KC && idx_i_q == {rc4_pkg::PermAw{1'b1}}) |=>
    (state_q == ST_IDLE && idx_i_q == '0 && idx_j_q == '0 && key_cnt_q == '0))
    else $error("key schedule did not end cleanly");

  // The cyclic key index stays within the stored key.
  a_kidx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_KR |-> {1'b0, kidx_q} < key_cnt_q)
    else $error("key index outside the stored key");
`endif

endmodule

// ===== tb/rc4_stream_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RC4 stream checker
// Watches both stream channels of the RC4 core. It keeps its own permutation,
// key store and keystream indices, predicts the byte for every accepted data
// transaction and compares each output transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module rc4_stream_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Input stream, observed
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  input  logic [rc4_pkg::ByteW-1:0] s_axis_tdata,   // [7:0] byte_value
  input  logic                      s_axis_tuser,   // [0] cmd
  input  logic                      s_axis_tlast,   // last_key
  // Output stream, observed
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  input  logic [rc4_pkg::ByteW-1:0] m_axis_tdata,   // [7:0] data_out
  // Status toward the testbench top
  output int                        fail_count_o,
  output int                        pending_o
);

  typedef logic [rc4_pkg::ByteW-1:0] byte_t;

  // Predicted cipher state.
  byte_t                       sbox    [rc4_pkg::PermDepth];
  byte_t                       key_mem [rc4_pkg::KeyDepth];
  logic [rc4_pkg::KeyCntW-1:0] key_len;
  byte_t                       ptr_i;
  byte_t                       ptr_j;

  // Output bytes still owed by the core, oldest first.
  byte_t              cipher_bytes_q [$];

  function automatic void load_identity();
    for (int k = 0; k < rc4_pkg::PermDepth; k++) sbox[k] = byte_t'(k);
  endfunction

  function automatic void swap_sbox(byte_t a, byte_t b);
    byte_t t;
    t       = sbox[a];
    sbox[a] = sbox[b];
    sbox[b] = t;
  endfunction

  // Key schedule over the identity permutation, key repeated cyclically.
  function automatic void schedule_key();
    byte_t acc;
    byte_t kb;
    acc = '0;
    load_identity();
    for (int k = 0; k < rc4_pkg::PermDepth; k++) begin
      kb  = (key_len != 0) ? key_mem[k % key_len] : '0;
      acc = acc + sbox[k] + kb;
      swap_sbox(byte_t'(k), acc);
    end
    ptr_i   = '0;
    ptr_j   = '0;
    key_len = '0;
  endfunction

  // One keystream step; returns the input byte XORed with the keystream byte.
  function automatic byte_t crypt_byte(byte_t din);
    byte_t idx;
    ptr_i = ptr_i + 1'b1;
    ptr_j = ptr_j + sbox[ptr_i];
    swap_sbox(ptr_i, ptr_j);
    idx = sbox[ptr_i] + sbox[ptr_j];
    return din ^ sbox[idx];
  endfunction

  // Output side is handled before input side: a result never belongs to a
  // byte accepted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    byte_t want;
    if (!rst_ni) begin
      load_identity();
      key_len = '0;
      ptr_i   = '0;
      ptr_j   = '0;
      cipher_bytes_q.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (cipher_bytes_q.size() == 0) begin
          $display("%0t: unexpected output transaction, expected none, got %02h",
                   $time, m_axis_tdata);
          fail_count_o++;
        end else begin
          want = cipher_bytes_q.pop_front();
          if (want !== m_axis_tdata) begin
            $display("%0t: data_out mismatch, expected %02h, got %02h",
                     $time, want, m_axis_tdata);
            fail_count_o++;
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == rc4_pkg::CmdKey) begin
          // Bytes past the longest key are dropped, the mark still counts.
          if (key_len < rc4_pkg::MaxKeyBytes) begin
            key_mem[key_len[rc4_pkg::KeyAw-1:0]] = s_axis_tdata;
            key_len++;
          end
          if (s_axis_tlast) schedule_key();
        end else begin
          cipher_bytes_q.push_back(crypt_byte(s_axis_tdata));
        end
      end

      pending_o = cipher_bytes_q.size();
    end
  end

endmodule

// ===== tb/tb_rc4_stream_cipher_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RC4 stream cipher core testbench
// Drives key and data transactions into the core with random gaps and output
// back-pressure, including one long output stall, and leaves prediction and
// comparison to the stream checker. Prints the verdict at the end.
// ----------------------------------------------------------------------------
module tb_rc4_stream_cipher_core;

  typedef logic [rc4_pkg::ByteW-1:0] byte_t;

  localparam int ItemTarget  = 1950;
  localparam int IdleLimit   = 8000;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  byte_t       s_axis_tdata;   // [7:0] byte_value
  logic        s_axis_tuser;   // [0] cmd
  logic        s_axis_tlast;   // last_key
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  byte_t       m_axis_tdata;   // [7:0] data_out

  int          fail_count;
  int          pending;
  int          items_sent;
  bit          no_idle;
  bit          hold_off_req;

  always #5 clk_i = ~clk_i;

  rc4_stream_cipher_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  rc4_stream_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Offer one transaction after a random gap and wait until it is taken.
  task automatic send_item(logic cmd, byte_t val, logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= val;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // Random key bytes; the final one optionally carries the schedule mark.
  task automatic send_key(int len, bit mark_last);
    for (int k = 0; k < len; k++)
      send_item(rc4_pkg::CmdKey, byte_t'($urandom_range(0, 255)),
                mark_last && (k == len - 1));
  endtask

  // Random data bytes; tlast is noise on data and is set at random.
  task automatic send_data(int len);
    for (int k = 0; k < len; k++)
      send_item(rc4_pkg::CmdData, byte_t'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
  endtask

  // Output side: random ready gaps, plus one long hold when requested.
  initial begin : receiver
    int wait_cycles;
    m_axis_tready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        wait_cycles  = HoldCycles;
        hold_off_req = 1'b0;
      end else begin
        wait_cycles = no_idle ? 0 : $urandom_range(0, 5);
      end
      if (wait_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Ends the run when neither channel moves for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no transaction for %0d cycles", $time, IdleLimit);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int pick;
    int len;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = rc4_pkg::CmdKey;
    s_axis_tlast  = 1'b0;
    items_sent    = 0;
    no_idle       = 1'b0;
    hold_off_req  = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Data before any key runs on the identity permutation; tlast is ignored.
    send_item(rc4_pkg::CmdData, 8'h00, 1'b1);
    send_item(rc4_pkg::CmdData, 8'hFF, 1'b0);
    send_item(rc4_pkg::CmdData, 8'h80, 1'b0);

    // Shortest key, an all-zero byte.
    send_item(rc4_pkg::CmdKey,  8'h00, 1'b1);
    send_item(rc4_pkg::CmdData, 8'h01, 1'b0);
    send_item(rc4_pkg::CmdData, 8'hFE, 1'b1);

    // Three-byte key with extreme values.
    send_item(rc4_pkg::CmdKey,  8'hFF, 1'b0);
    send_item(rc4_pkg::CmdKey,  8'h7F, 1'b0);
    send_item(rc4_pkg::CmdKey,  8'h01, 1'b1);
    send_item(rc4_pkg::CmdData, 8'hFF, 1'b0);
    send_item(rc4_pkg::CmdData, 8'h00, 1'b0);

    // Key load interrupted by data, which still uses the old permutation.
    send_item(rc4_pkg::CmdKey,  8'hAA, 1'b0);
    send_item(rc4_pkg::CmdData, 8'h55, 1'b0);
    send_item(rc4_pkg::CmdKey,  8'h55, 1'b1);
    send_data(3);

    // Full-length key, then an overflowing key with the mark on a dropped byte.
    send_key(rc4_pkg::KeyDepth, 1'b1);
    send_data(8);
    send_key(rc4_pkg::KeyDepth + 4, 1'b1);
    send_data(8);

    // Long output stall while data keeps coming, so the input backs up.
    hold_off_req = 1'b1;
    no_idle      = 1'b1;
    send_data(40);

    // Mostly complete key-then-data sequences, with some broken ones.
    while (items_sent < ItemTarget) begin
      no_idle = ($urandom_range(0, 4) == 0);
      pick    = $urandom_range(0, 9);
      if (pick <= 6) begin
        len = $urandom_range(0, 63);
        if (len == 0)      len = $urandom_range(250, 270);
        else if (len <= 8) len = $urandom_range(17, 64);
        else               len = $urandom_range(1, 16);
        send_key(len, 1'b1);
        send_data($urandom_range(1, 48));
      end else if (pick == 7) begin
        send_data($urandom_range(1, 20));
      end else if (pick == 8) begin
        send_key($urandom_range(1, 8), 1'b0);
        send_data($urandom_range(1, 8));
      end else begin
        send_key(1, 1'b1);
      end
    end
    s_axis_tvalid <= 1'b0;
    no_idle = 1'b0;

    // Wait for every owed result, then let the pipeline settle.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
